[rtl/tccs_pkg.sv]
// Package for the text console engine: item structs, queue command type and constants.
// Used by every module of the console except tccs_ram; depends on nothing.
package tccs_pkg;

  localparam int OPC_W = 2;
  localparam int CHR_W = 8;
  localparam int COL_W = 7;
  localparam int ROW_W = 5;
  localparam int CLR_W = 8;
  localparam int CELL_W = CHR_W + CLR_W;

  // Opcodes of an input item.
  localparam logic [OPC_W-1:0] OP_PUT   = 2'd0;
  localparam logic [OPC_W-1:0] OP_WRITE = 2'd1;
  localparam logic [OPC_W-1:0] OP_READ  = 2'd2;
  localparam logic [OPC_W-1:0] OP_CLEAR = 2'd3;

  // Character codes with a meaning of their own.
  localparam logic [CHR_W-1:0] CH_BACKSPACE = 8'd8;
  localparam logic [CHR_W-1:0] CH_NEWLINE   = 8'd10;
  localparam logic [CHR_W-1:0] CH_PRINT_LO  = 8'd32;
  localparam logic [CHR_W-1:0] CH_PRINT_HI  = 8'd126;
  localparam logic [CHR_W-1:0] BLANK_CHAR   = 8'h20;
  localparam logic [CLR_W-1:0] RESET_COLOR  = 8'h07;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

  // Command kinds decided by the front end.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] K_IGNORE    = 3'd0;
  localparam logic [KIND_W-1:0] K_NEWLINE   = 3'd1;
  localparam logic [KIND_W-1:0] K_BACKSPACE = 3'd2;
  localparam logic [KIND_W-1:0] K_PRINT     = 3'd3;
  localparam logic [KIND_W-1:0] K_WRITE     = 3'd4;
  localparam logic [KIND_W-1:0] K_READ      = 3'd5;
  localparam logic [KIND_W-1:0] K_CLEAR     = 3'd6;
  localparam logic [KIND_W-1:0] K_OFFSCREEN = 3'd7;

  typedef struct packed {
    logic [OPC_W-1:0] opcode;
    logic [CHR_W-1:0] char_code;
    logic [COL_W-1:0] at_col;
    logic [ROW_W-1:0] at_row;
    logic [CLR_W-1:0] color_in;
  } in_item_t;

  typedef struct packed {
    logic [COL_W-1:0] out_col;
    logic [ROW_W-1:0] out_row;
    logic [CHR_W-1:0] cell_char;
    logic [CLR_W-1:0] cell_color;
    logic             position_ok;
  } out_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [CHR_W-1:0]  ch;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic [CLR_W-1:0]  color;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_stat_t;

endpackage

[rtl/text_console_cursor_scroll.sv]
// Top level of the text console engine: front end, command queue, back end and
// the text color register. Depends on tccs_pkg, tccs_front, tccs_queue, tccs_back.
//
//  Channel  Ports                         Handshake
//  input    start, busy, in_item          taken when start is high and busy is low
//  result   out_strobe, out_item          valid for one cycle, cannot be held off
//  config   cfg_valid, cfg_ready, cfg_data written when cfg_valid and cfg_ready are high
//
// Put-character, write-cell and ignored items finish in the back end's idle state; a
// read passes through the read state for the registered memory read. A line feed on
// the bottom row scrolls by moving the row-offset ring and blanking one row. Clear
// screen sweeps the whole memory. After reset the whole memory is swept with busy high.
// A two-entry queue lets items be taken while the back end works; results leave
// without stall.
module text_console_cursor_scroll #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  tccs_pkg::in_item_t         in_item,
  output logic                       out_strobe,
  output tccs_pkg::out_item_t        out_item,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [tccs_pkg::CLR_W-1:0] cfg_data
);
  import tccs_pkg::*;

  logic             [CLR_W-1:0] text_color_r;
  logic             q_push;
  logic             q_pop;
  logic             back_init;
  cmd_t             push_cmd;
  cmd_t             head_cmd;
  q_stat_t          q_stat;

  // Text color register; writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      text_color_r <= RESET_COLOR;
    end else if (cfg_valid && cfg_ready) begin
      text_color_r <= cfg_data;
    end
  end

  tccs_front #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_front (
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .q_stat    (q_stat),
    .back_init (back_init),
    .q_push    (q_push),
    .q_cmd     (push_cmd)
  );

  tccs_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .head_cmd (head_cmd),
    .stat     (q_stat)
  );

  tccs_back #(
    .SCREEN_COLS (SCREEN_COLS),
    .SCREEN_ROWS (SCREEN_ROWS)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_stat     (q_stat),
    .q_cmd      (head_cmd),
    .q_pop      (q_pop),
    .text_color (text_color_r),
    .back_init  (back_init),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );
endmodule

[rtl/tccs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tccs_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2000
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

[rtl/tccs_front.sv]
// Front end: takes input items and sorts them into command kinds for the queue.
// Depends on tccs_pkg.
module tccs_front #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic               start,
  output logic               busy,
  input  tccs_pkg::in_item_t in_item,
  input  tccs_pkg::q_stat_t  q_stat,
  input  logic               back_init,
  output logic               q_push,
  output tccs_pkg::cmd_t     q_cmd
);
  import tccs_pkg::*;

  logic on_screen;
  logic printable;

  // The block refuses items while the queue is full or the screen is being cleared after reset.
  assign busy   = q_stat.full | back_init;
  assign q_push = start & ~busy;

  assign on_screen = ({1'b0, in_item.at_col} < 8'(SCREEN_COLS)) &&
                     ({1'b0, in_item.at_row} < 6'(SCREEN_ROWS));
  assign printable = (in_item.char_code >= CH_PRINT_LO) && (in_item.char_code <= CH_PRINT_HI);

  // Decode the opcode and character into one command kind.
  always_comb begin
    q_cmd.ch    = in_item.char_code;
    q_cmd.col   = in_item.at_col;
    q_cmd.row   = in_item.at_row;
    q_cmd.color = in_item.color_in;
    unique case (in_item.opcode)
      OP_PUT: begin
        if (in_item.char_code == CH_NEWLINE) begin
          q_cmd.kind = K_NEWLINE;
        end else if (in_item.char_code == CH_BACKSPACE) begin
          q_cmd.kind = K_BACKSPACE;
        end else if (printable) begin
          q_cmd.kind = K_PRINT;
        end else begin
          q_cmd.kind = K_IGNORE;
        end
      end
      OP_WRITE: q_cmd.kind = on_screen ? K_WRITE : K_OFFSCREEN;
      OP_READ:  q_cmd.kind = on_screen ? K_READ : K_OFFSCREEN;
      default:  q_cmd.kind = K_CLEAR;
    endcase
  end
endmodule

[rtl/tccs_queue.sv]
// Two-entry command queue between the front end and the back end.
// Depends on tccs_pkg.
module tccs_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  tccs_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output tccs_pkg::cmd_t    head_cmd,
  output tccs_pkg::q_stat_t stat
);
  import tccs_pkg::*;

  cmd_t              ent_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign head_cmd   = ent_r[rd_ptr_r];

  // Pointer and count update.
  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + QCNT_W'(push) - QCNT_W'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_cmd;
    end
  end

  // The front end must never push into a full queue.
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(push && stat.full && !pop))
    else $error("command queue overflow");

  // The back end must never pop an empty queue.
  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !(pop && stat.empty))
    else $error("command queue underflow");

  // The fill count stays within the queue depth.
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= QCNT_W'(QUEUE_DEPTH))
    else $error("command queue count out of range");
endmodule

[rtl/tccs_back.sv]
// Back end: executes queued commands on the screen memory, keeps the cursor and
// the row-offset ring, and drives the result strobe. Depends on tccs_pkg, tccs_ram.
module tccs_back #(
  parameter int SCREEN_COLS = 80,
  parameter int SCREEN_ROWS = 25
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  tccs_pkg::q_stat_t            q_stat,
  input  tccs_pkg::cmd_t               q_cmd,
  output logic                         q_pop,
  input  logic [tccs_pkg::CLR_W-1:0]   text_color,
  output logic                         back_init,
  output logic                         out_strobe,
  output tccs_pkg::out_item_t          out_item
);
  import tccs_pkg::*;

  localparam int CELLS  = SCREEN_COLS * SCREEN_ROWS;
  localparam int ADDR_W = $clog2(CELLS);
  localparam logic [ADDR_W-1:0] COLS_A    = ADDR_W'(SCREEN_COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL = ADDR_W'(CELLS - 1);
  localparam logic [COL_W-1:0]  LAST_COL  = COL_W'(SCREEN_COLS - 1);
  localparam logic [ROW_W-1:0]  LAST_ROW  = ROW_W'(SCREEN_ROWS - 1);

  localparam logic [1:0] S_INIT  = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_SWEEP = 2'd2;
  localparam logic [1:0] S_READ  = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [COL_W-1:0]  col_r, col_nxt;
  logic [ROW_W-1:0]  row_r, row_nxt;
  logic [ROW_W-1:0]  top_r, top_nxt;
  logic [ADDR_W-1:0] sw_addr_r, sw_addr_nxt;
  logic [ADDR_W-1:0] sw_last_r, sw_last_nxt;
  logic [CELL_W-1:0] sw_data_r, sw_data_nxt;
  logic              sw_emit_r, sw_emit_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_r, out_nxt;

  logic [COL_W-1:0]  sel_col;
  logic [ROW_W-1:0]  sel_row;
  logic [ROW_W:0]    prow_sum;
  logic [ROW_W-1:0]  prow;
  logic [ADDR_W-1:0] cell_addr;
  logic [ADDR_W-1:0] top_addr;
  logic [COL_W-1:0]  bs_col;
  logic [ROW_W-1:0]  bs_row;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [CELL_W-1:0] ram_wdata;
  logic [CELL_W-1:0] ram_rdata;
  logic              cmd_ok;
  logic              go_next_row;
  logic [CELL_W-1:0] blank;

  assign blank     = {text_color, BLANK_CHAR};
  assign back_init = (state_r == S_INIT);

  // Cursor position after a backspace.
  always_comb begin
    bs_col = col_r;
    bs_row = row_r;
    if (col_r != '0) begin
      bs_col = col_r - 1'b1;
    end else if (row_r != '0) begin
      bs_row = row_r - 1'b1;
      bs_col = LAST_COL;
    end
  end

  // Choose the logical cell the command touches.
  always_comb begin
    case (q_cmd.kind)
      K_BACKSPACE: begin
        sel_col = bs_col;
        sel_row = bs_row;
      end
      K_WRITE, K_READ: begin
        sel_col = q_cmd.col;
        sel_row = q_cmd.row;
      end
      default: begin
        sel_col = col_r;
        sel_row = row_r;
      end
    endcase
  end

  // Map the logical row through the ring offset and form the cell address.
  assign prow_sum  = {1'b0, sel_row} + {1'b0, top_r};
  assign prow      = (prow_sum >= (ROW_W + 1)'(SCREEN_ROWS)) ?
                     ROW_W'(prow_sum - (ROW_W + 1)'(SCREEN_ROWS)) : prow_sum[ROW_W-1:0];
  assign cell_addr = ADDR_W'(prow) * COLS_A + ADDR_W'(sel_col);
  assign top_addr  = ADDR_W'(top_r) * COLS_A;

  assign go_next_row = (q_cmd.kind == K_NEWLINE) ||
                       ((q_cmd.kind == K_PRINT) && (col_r == LAST_COL));

  // Command execution and sweeps.
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    top_nxt       = top_r;
    sw_addr_nxt   = sw_addr_r;
    sw_last_nxt   = sw_last_r;
    sw_data_nxt   = sw_data_r;
    sw_emit_nxt   = sw_emit_r;
    ram_we        = 1'b0;
    ram_waddr     = cell_addr;
    ram_wdata     = blank;
    q_pop         = 1'b0;
    out_valid_nxt = 1'b0;
    cmd_ok        = 1'b0;
    out_nxt       = '0;
    unique case (state_r)
      S_INIT, S_SWEEP: begin
        ram_we      = 1'b1;
        ram_waddr   = sw_addr_r;
        ram_wdata   = sw_data_r;
        sw_addr_nxt = sw_addr_r + 1'b1;
        if (sw_addr_r == sw_last_r) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = sw_emit_r;
        end
      end
      S_IDLE: begin
        if (!q_stat.empty) begin
          q_pop = 1'b1;
          case (q_cmd.kind)
            K_PRINT: begin
              ram_we    = 1'b1;
              ram_wdata = {text_color, q_cmd.ch};
              col_nxt   = col_r + 1'b1;
            end
            K_BACKSPACE: begin
              ram_we  = 1'b1;
              col_nxt = bs_col;
              row_nxt = bs_row;
            end
            K_WRITE: begin
              ram_we    = 1'b1;
              ram_wdata = {q_cmd.color, q_cmd.ch};
              cmd_ok    = 1'b1;
            end
            K_CLEAR: begin
              col_nxt     = '0;
              row_nxt     = '0;
              top_nxt     = '0;
              sw_addr_nxt = '0;
              sw_last_nxt = LAST_CELL;
              sw_data_nxt = blank;
              sw_emit_nxt = 1'b1;
              state_nxt   = S_SWEEP;
            end
            default: begin
            end
          endcase
          if (go_next_row) begin
            col_nxt = '0;
            if (row_r == LAST_ROW) begin
              // Scroll: the top physical row becomes the blank bottom row.
              top_nxt     = (top_r == LAST_ROW) ? '0 : top_r + 1'b1;
              sw_addr_nxt = top_addr;
              sw_last_nxt = top_addr + COLS_A - 1'b1;
              sw_data_nxt = blank;
              sw_emit_nxt = 1'b1;
              state_nxt   = S_SWEEP;
            end else begin
              row_nxt = row_r + 1'b1;
            end
          end
          if (q_cmd.kind == K_READ) begin
            state_nxt = S_READ;
          end else if (state_nxt == S_IDLE) begin
            out_valid_nxt = 1'b1;
          end
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        out_valid_nxt = 1'b1;
        cmd_ok        = 1'b1;
        out_nxt.cell_char  = ram_rdata[CHR_W-1:0];
        out_nxt.cell_color = ram_rdata[CELL_W-1:CHR_W];
      end
    endcase
    out_nxt.out_col     = col_nxt;
    out_nxt.out_row     = row_nxt;
    out_nxt.position_ok = cmd_ok;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_INIT;
      col_r       <= '0;
      row_r       <= '0;
      top_r       <= '0;
      sw_addr_r   <= '0;
      sw_last_r   <= LAST_CELL;
      sw_data_r   <= {RESET_COLOR, BLANK_CHAR};
      sw_emit_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      top_r       <= top_nxt;
      sw_addr_r   <= sw_addr_nxt;
      sw_last_r   <= sw_last_nxt;
      sw_data_r   <= sw_data_nxt;
      sw_emit_r   <= sw_emit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Result payload needs no reset.
  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  tccs_ram #(
    .WIDTH (CELL_W),
    .DEPTH (CELLS)
  ) u_screen (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cell_addr),
    .rdata (ram_rdata)
  );

  assign out_strobe = out_valid_r;
  assign out_item   = out_r;

  // The cursor and the ring offset stay on screen.
  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, col_r} < 8'(SCREEN_COLS)) && ({1'b0, row_r} < 6'(SCREEN_ROWS)) &&
    ({1'b0, top_r} < 6'(SCREEN_ROWS)))
    else $error("cursor or ring offset off screen");

  // A read result is delivered in the cycle after the read state.
  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("read result missing");

  // No result comes out while the screen is cleared after reset.
  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INIT) |-> !out_valid_r)
    else $error("result during reset clear");
endmodule

[dv/text_console_cursor_scroll_tb.sv]
// Self-checking testbench for the text console engine: directed items, then random phases.
// Each phase uses its own text color. Depends on tccs_pkg and text_console_cursor_scroll.
// Results are checked against a shadow screen, cursor and color kept in this file.
module text_console_cursor_scroll_tb;
  import tccs_pkg::*;

  localparam int SCR_COLS = 80;
  localparam int SCR_ROWS = 25;
  localparam int SCR_CELLS = SCR_COLS * SCR_ROWS;
  localparam int PHASES = 5;
  localparam int PHASE_ITEMS = 90;
  localparam int SETTLE_CYCLES = 100;
  localparam int MAX_REPORTS = 10;

  // One directed item, with its result typed in where it is obvious.
  typedef struct packed {
    in_item_t  item;
    logic      known;
    out_item_t result;
  } directed_row_t;

  logic            clk = 1'b0;
  logic            rst_n = 1'b0;
  logic            start = 1'b0;
  logic            busy;
  in_item_t        in_item = '0;
  logic            out_strobe;
  out_item_t       out_item;
  logic            cfg_valid = 1'b0;
  logic            cfg_ready;
  logic [CLR_W-1:0] cfg_data = '0;

  // Shadow of the screen store, cursor and text color.
  logic [CELL_W-1:0] shadow_cells [SCR_CELLS];
  logic [COL_W-1:0]  shadow_col;
  logic [ROW_W-1:0]  shadow_row;
  logic [CLR_W-1:0]  shadow_color;

  out_item_t     pending_results[$];
  directed_row_t directed_rows[$];
  out_item_t     expected_head;
  logic          result_bad;
  int            mismatch_count = 0;
  int            items_sent = 0;
  int            results_seen = 0;
  int            scroll_count = 0;
  int            clear_count = 0;
  int            offscreen_count = 0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  text_console_cursor_scroll #(
    .SCREEN_COLS(SCR_COLS),
    .SCREEN_ROWS(SCR_ROWS)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Move the cursor to the start of the next line, scrolling on the bottom row.
  function automatic void advance_line();
    int i;
    shadow_col = '0;
    if (shadow_row < SCR_ROWS - 1) begin
      shadow_row++;
    end else begin
      for (i = 0; i < SCR_CELLS - SCR_COLS; i++) shadow_cells[i] = shadow_cells[i + SCR_COLS];
      for (i = SCR_CELLS - SCR_COLS; i < SCR_CELLS; i++) shadow_cells[i] = {shadow_color, BLANK_CHAR};
      scroll_count++;
    end
  endfunction

  // Apply one item to the shadow console and return the result it produces.
  function automatic out_item_t console_step(in_item_t it);
    out_item_t res;
    int        idx;
    logic      on_screen;
    int        i;
    res = '0;
    on_screen = (it.at_col < SCR_COLS) && (it.at_row < SCR_ROWS);
    idx = int'(it.at_row) * SCR_COLS + int'(it.at_col);
    case (it.opcode)
      OP_PUT: begin
        if (it.char_code == CH_NEWLINE) begin
          advance_line();
        end else if (it.char_code == CH_BACKSPACE) begin
          if (shadow_col > 0) begin
            shadow_col--;
          end else if (shadow_row > 0) begin
            shadow_row--;
            shadow_col = COL_W'(SCR_COLS - 1);
          end
          shadow_cells[int'(shadow_row) * SCR_COLS + int'(shadow_col)] = {shadow_color, BLANK_CHAR};
        end else if (it.char_code >= CH_PRINT_LO && it.char_code <= CH_PRINT_HI) begin
          shadow_cells[int'(shadow_row) * SCR_COLS + int'(shadow_col)] =
            {shadow_color, it.char_code};
          if (shadow_col == SCR_COLS - 1) advance_line();
          else shadow_col++;
        end
      end
      OP_WRITE: begin
        if (on_screen) begin
          shadow_cells[idx] = {it.color_in, it.char_code};
          res.position_ok = 1'b1;
        end else begin
          offscreen_count++;
        end
      end
      OP_READ: begin
        if (on_screen) begin
          res.cell_char = shadow_cells[idx][CHR_W-1:0];
          res.cell_color = shadow_cells[idx][CELL_W-1:CHR_W];
          res.position_ok = 1'b1;
        end else begin
          offscreen_count++;
        end
      end
      default: begin
        shadow_col = '0;
        shadow_row = '0;
        for (i = 0; i < SCR_CELLS; i++) shadow_cells[i] = {shadow_color, BLANK_CHAR};
        clear_count++;
      end
    endcase
    res.out_col = shadow_col;
    res.out_row = shadow_row;
    return res;
  endfunction

  // Idle cycles before an item: mostly none or short, now and then long.
  function automatic int pick_gap(logic no_idle);
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Random item. Typing phases favor printing and line feeds so the screen scrolls.
  function automatic in_item_t random_item(logic typing);
    in_item_t it;
    int       r;
    int       pick;
    it = in_item_t'($urandom);
    r = $urandom_range(0, 99);
    pick = $urandom_range(0, 99);
    if (typing) begin
      it.opcode = (r < 85) ? OP_PUT : (r < 92) ? OP_WRITE : OP_READ;
    end else begin
      it.opcode = (r < 45) ? OP_PUT : (r < 62) ? OP_WRITE : (r < 96) ? OP_READ : OP_CLEAR;
    end
    if (it.opcode == OP_PUT) begin
      if (pick < (typing ? 40 : 12)) it.char_code = CH_NEWLINE;
      else if (pick < (typing ? 48 : 22)) it.char_code = CH_BACKSPACE;
      else if (pick < (typing ? 92 : 82))
        it.char_code = CHR_W'($urandom_range(CH_PRINT_LO, CH_PRINT_HI));
    end else if (it.opcode == OP_WRITE || it.opcode == OP_READ) begin
      // Some positions keep their full random range and may fall off screen.
      if (pick >= 15) begin
        it.at_col = COL_W'($urandom_range(0, SCR_COLS - 1));
        if (it.opcode == OP_READ && pick < 45) it.at_row = shadow_row;
        else it.at_row = ROW_W'($urandom_range(0, SCR_ROWS - 1));
      end
    end
    return it;
  endfunction

  function automatic void add_row(logic [OPC_W-1:0] op, logic [CHR_W-1:0] ch,
                                  logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                  logic [CLR_W-1:0] clr);
    directed_rows.push_back({op, ch, col, row, clr, 1'b0, out_item_t'('0)});
  endfunction

  function automatic void add_known(logic [OPC_W-1:0] op, logic [CHR_W-1:0] ch,
                                    logic [COL_W-1:0] col, logic [ROW_W-1:0] row,
                                    logic [CLR_W-1:0] clr, logic [COL_W-1:0] ecol,
                                    logic [ROW_W-1:0] erow, logic [CHR_W-1:0] ech,
                                    logic [CLR_W-1:0] eclr, logic eok);
    directed_rows.push_back({op, ch, col, row, clr, 1'b1, ecol, erow, ech, eclr, eok});
  endfunction

  // Present one item and hold it until it is taken, then record its result.
  // Called right after a rising edge; start stays high between back-to-back items.
  task automatic send_item(input in_item_t it, input logic known, input out_item_t known_res,
                           input logic no_idle);
    int        gap;
    out_item_t predicted;
    gap = pick_gap(no_idle);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!(start && !busy));
    predicted = console_step(it);
    pending_results.push_back(known ? known_res : predicted);
    items_sent++;
  endtask

  // Drain all results, then write the text color while the block is idle.
  task automatic write_text_color(input logic [CLR_W-1:0] value);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    @(posedge clk);
    // Let the back end finish its last item before the write.
    repeat (4) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= value;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    shadow_color = value;
  endtask

  // Check every result against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("ERROR: unexpected result col %0d row %0d char %02h color %02h ok %0b",
                   out_item.out_col, out_item.out_row, out_item.cell_char,
                   out_item.cell_color, out_item.position_ok);
      end else begin
        expected_head = pending_results.pop_front();
        result_bad = (out_item.out_col !== expected_head.out_col) ||
                     (out_item.out_row !== expected_head.out_row) ||
                     (out_item.cell_char !== expected_head.cell_char) ||
                     (out_item.cell_color !== expected_head.cell_color) ||
                     (out_item.position_ok !== expected_head.position_ok);
        if (result_bad) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("ERROR: result %0d: expected col %0d row %0d char %02h color %02h ok %0b, %s",
                     results_seen, expected_head.out_col, expected_head.out_row,
                     expected_head.cell_char, expected_head.cell_color,
                     expected_head.position_ok,
                     $sformatf("got col %0d row %0d char %02h color %02h ok %0b",
                               out_item.out_col, out_item.out_row, out_item.cell_char,
                               out_item.cell_color, out_item.position_ok));
        end
      end
    end
  end

  // Stimulus: directed items at the reset color, then random phases.
  initial begin
    int           p;
    int           n;
    logic         typing;
    logic [CLR_W-1:0] phase_color;
    shadow_color = RESET_COLOR;
    shadow_col = '0;
    shadow_row = '0;
    for (n = 0; n < SCR_CELLS; n++) shadow_cells[n] = {RESET_COLOR, BLANK_CHAR};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Store after reset, far corners, off-screen positions and backspace at home.
    add_known(OP_READ,  8'h00, 7'd0,   5'd0,  8'h00, 7'd0, 5'd0, BLANK_CHAR, RESET_COLOR, 1'b1);
    add_known(OP_READ,  8'h00, 7'd127, 5'd31, 8'h00, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    add_known(OP_READ,  8'h00, 7'd79,  5'd24, 8'h00, 7'd0, 5'd0, BLANK_CHAR, RESET_COLOR, 1'b1);
    add_known(OP_WRITE, 8'hFF, 7'd79,  5'd24, 8'hFF, 7'd0, 5'd0, 8'h00, 8'h00, 1'b1);
    add_known(OP_READ,  8'h00, 7'd79,  5'd24, 8'h00, 7'd0, 5'd0, 8'hFF, 8'hFF, 1'b1);
    add_known(OP_WRITE, 8'h41, 7'd80,  5'd24, 8'h1F, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    add_known(OP_WRITE, 8'h41, 7'd0,   5'd25, 8'h1F, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    add_known(OP_WRITE, 8'hFF, 7'd127, 5'd31, 8'hFF, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    add_known(OP_PUT,   CH_BACKSPACE, 7'd0, 5'd0, 8'h00, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    add_known(OP_READ,  8'h00, 7'd0,   5'd0,  8'h00, 7'd0, 5'd0, BLANK_CHAR, RESET_COLOR, 1'b1);
    // Printable limits, ignored bytes, line feed, backspace across a row and wrap.
    add_row(OP_PUT, 8'h41, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, CH_PRINT_HI, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, CH_PRINT_LO, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, 8'd127, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, 8'd31, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, 8'd0, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, 8'hFF, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, CH_NEWLINE, 7'd0, 5'd0, 8'h00);
    add_row(OP_PUT, CH_BACKSPACE, 7'd0, 5'd0, 8'h00);
    add_row(OP_READ, 8'h00, 7'd79, 5'd0, 8'h00);
    add_row(OP_PUT, 8'h5A, 7'd0, 5'd0, 8'h00);
    add_row(OP_READ, 8'h00, 7'd0, 5'd0, 8'h00);
    add_row(OP_WRITE, 8'h00, 7'd0, 5'd0, 8'h00);
    add_known(OP_CLEAR, 8'h00, 7'd0, 5'd0, 8'h00, 7'd0, 5'd0, 8'h00, 8'h00, 1'b0);
    add_known(OP_READ,  8'h00, 7'd0, 5'd0, 8'h00, 7'd0, 5'd0, BLANK_CHAR, RESET_COLOR, 1'b1);

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].known, directed_rows[i].result, 1'b0);

    // Random phases, each with its own color; odd phases type text and scroll.
    for (p = 0; p < PHASES; p++) begin
      case (p)
        0: phase_color = 8'h00;
        1: phase_color = 8'hFF;
        default: phase_color = CLR_W'($urandom_range(0, 255));
      endcase
      write_text_color(phase_color);
      typing = p[0];
      for (n = 0; n < PHASE_ITEMS; n++)
        send_item(random_item(typing), 1'b0, '0, p == 2);
    end

    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d items and %0d results: %0d scrolls, %0d clears, %0d off-screen accesses.",
             items_sent, results_seen, scroll_count, clear_count, offscreen_count);
    $display("Mismatches: %0d, results still expected: %0d.", mismatch_count,
             pending_results.size());
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Watchdog against a hung handshake.
  initial begin
    #8000000;
    $display("Test completed with failures");
    $finish;
  end

endmodule

[sim.f]
rtl/tccs_pkg.sv
rtl/tccs_ram.sv
rtl/tccs_front.sv
rtl/tccs_queue.sv
rtl/tccs_back.sv
rtl/text_console_cursor_scroll.sv
dv/text_console_cursor_scroll_tb.sv
